>>> rtl/sopm_pkg.sv
// ----------------------------------------------------------------------------
// sopm_pkg
// Shared widths, opcodes, register indexes, cosine table and helpers for the
// stereo object mixer.
// ----------------------------------------------------------------------------
package sopm_pkg;

  localparam int FRAME_W     = 8;
  localparam int SAMPLE_W    = 16;
  localparam int AZ_W        = 10;
  localparam int GAIN_W      = 16;
  localparam int PAN_W       = 16;
  localparam int COS_W       = 16;
  localparam int NORM_W      = 16;
  localparam int ACC_W       = 40;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int SAMPLE_BITS = 16;
  localparam int PROD_W      = SAMPLE_W + PAN_W + 1;
  localparam int FRAME_RANGE = 1 << FRAME_W;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_HEADER = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MIXER_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_TARGET   = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_THRESHOLD = 16'd5;
  localparam logic [GAIN_W-1:0] TARGET_RESET   = 16'd4096;
  localparam logic [15:0]       ALPHA_Q15      = 16'd9830;
  localparam logic [15:0]       ALPHA_REM_Q15  = 16'd22938;

  // Q1.15 cosine, 0..90 degrees
  localparam logic [COS_W-1:0] COS_Q15 [0:90] = '{
    16'd32768, 16'd32763, 16'd32748, 16'd32723, 16'd32688, 16'd32643, 16'd32588,
    16'd32524, 16'd32449, 16'd32365, 16'd32270, 16'd32166, 16'd32052, 16'd31928,
    16'd31795, 16'd31651, 16'd31499, 16'd31336, 16'd31164, 16'd30983, 16'd30792,
    16'd30592, 16'd30382, 16'd30163, 16'd29935, 16'd29698, 16'd29452, 16'd29197,
    16'd28932, 16'd28660, 16'd28378, 16'd28088, 16'd27789, 16'd27482, 16'd27166,
    16'd26842, 16'd26510, 16'd26170, 16'd25822, 16'd25466, 16'd25102, 16'd24730,
    16'd24351, 16'd23965, 16'd23571, 16'd23170, 16'd22763, 16'd22348, 16'd21926,
    16'd21498, 16'd21063, 16'd20622, 16'd20174, 16'd19720, 16'd19261, 16'd18795,
    16'd18324, 16'd17847, 16'd17364, 16'd16877, 16'd16384, 16'd15886, 16'd15384,
    16'd14876, 16'd14365, 16'd13848, 16'd13328, 16'd12803, 16'd12275, 16'd11743,
    16'd11207, 16'd10668, 16'd10126, 16'd9580,  16'd9032,  16'd8481,  16'd7927,
    16'd7371,  16'd6813,  16'd6252,  16'd5690,  16'd5126,  16'd4560,  16'd3993,
    16'd3425,  16'd2856,  16'd2286,  16'd1715,  16'd1144,  16'd572,   16'd0
  };

  typedef struct packed {
    logic mul_norm;
    logic mul_gain;
  } scale_ctl_t;

  // integer square root, used on constants only
  function automatic logic [16:0] isqrt33(input logic [32:0] x);
    logic [33:0] rem;
    logic [33:0] res;
    logic [33:0] one_v;
    rem   = {1'b0, x};
    res   = '0;
    one_v = 34'h1_0000_0000;
    for (int i = 0; i < 17; i++) begin
      if (rem >= res + one_v) begin
        rem = rem - (res + one_v);
        res = (res >> 1) + one_v;
      end else begin
        res = res >> 1;
      end
      one_v = one_v >> 2;
    end
    return res[16:0];
  endfunction

endpackage

>>> rtl/sopm_frame_store.sv
// ----------------------------------------------------------------------------
// sopm_frame_store
// Left and right accumulator memories, one write and one registered read
// port each, with a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module sopm_frame_store #(
  parameter int FRAME_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rd_en,
  input  logic [$clog2(FRAME_DEPTH)-1:0]        rd_addr,
  input  logic                                  wr_en,
  input  logic [$clog2(FRAME_DEPTH)-1:0]        wr_addr,
  input  logic signed [sopm_pkg::ACC_W-1:0]     wr_left,
  input  logic signed [sopm_pkg::ACC_W-1:0]     wr_right,
  output logic signed [sopm_pkg::ACC_W-1:0]     rd_left,
  output logic signed [sopm_pkg::ACC_W-1:0]     rd_right,
  output logic                                  clearing
);
  import sopm_pkg::*;

  localparam int ADDR_W = $clog2(FRAME_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_DEPTH - 1);

  logic signed [ACC_W-1:0] left_mem  [FRAME_DEPTH];
  logic signed [ACC_W-1:0] right_mem [FRAME_DEPTH];
  logic [ADDR_W-1:0]       clr_addr;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_addr;
  logic signed [ACC_W-1:0] mem_left;
  logic signed [ACC_W-1:0] mem_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    mem_we    = clearing || wr_en;
    mem_addr  = clearing ? clr_addr : wr_addr;
    mem_left  = clearing ? '0 : wr_left;
    mem_right = clearing ? '0 : wr_right;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      left_mem[mem_addr]  <= mem_left;
      right_mem[mem_addr] <= mem_right;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_left  <= left_mem[rd_addr];
      rd_right <= right_mem[rd_addr];
    end
  end

endmodule

>>> rtl/sopm_pan.sv
// ----------------------------------------------------------------------------
// sopm_pan
// Cosine pan law: folds azimuth -/+ 30 deg, looks up cosine, then scales by
// the object gain into the left and right pan gains.
// ----------------------------------------------------------------------------
module sopm_pan (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic                               commit,
  input  logic signed [sopm_pkg::AZ_W-1:0]   azimuth,
  input  logic [sopm_pkg::GAIN_W-1:0]        object_gain,
  output logic [sopm_pkg::PAN_W-1:0]         left_gain,
  output logic [sopm_pkg::PAN_W-1:0]         right_gain
);
  import sopm_pkg::*;

  localparam int D_W = AZ_W + 1;
  localparam logic signed [D_W-1:0] DEG_PAN  = 11'sd30;
  localparam logic signed [D_W-1:0] DEG_FULL = 11'sd360;
  localparam logic signed [D_W-1:0] DEG_HALF = 11'sd180;
  localparam logic signed [D_W-1:0] DEG_QTR  = 11'sd90;
  localparam int MUL_W = COS_W + GAIN_W + 1;
  localparam logic [MUL_W-1:0] RND_PAN = MUL_W'(1) << 14;

  function automatic logic [COS_W-1:0] fold_cos(input logic signed [D_W-1:0] d);
    logic signed [D_W-1:0] r1;
    logic signed [D_W-1:0] r2;
    logic signed [D_W-1:0] r3;
    logic signed [D_W-1:0] r4;
    r1 = (d < 0) ? d + DEG_FULL : d;
    r2 = (r1 < 0) ? r1 + DEG_FULL : r1;
    r3 = (r2 >= DEG_FULL) ? r2 - DEG_FULL : r2;
    r4 = (r3 > DEG_HALF) ? DEG_FULL - r3 : r3;
    if (r4 > DEG_QTR) begin
      return '0;
    end
    return COS_Q15[r4[6:0]];
  endfunction

  logic signed [D_W-1:0] deg_l;
  logic signed [D_W-1:0] deg_r;
  logic [COS_W-1:0]      cos_l;
  logic [COS_W-1:0]      cos_r;
  logic [GAIN_W-1:0]     gain_q;
  logic [MUL_W-1:0]      mul_l;
  logic [MUL_W-1:0]      mul_r;

  assign deg_l = {azimuth[AZ_W-1], azimuth} - DEG_PAN;
  assign deg_r = {azimuth[AZ_W-1], azimuth} + DEG_PAN;

  always_ff @(posedge clk) begin
    if (load) begin
      cos_l  <= fold_cos(deg_l);
      cos_r  <= fold_cos(deg_r);
      gain_q <= object_gain;
    end
  end

  assign mul_l = MUL_W'(cos_l) * MUL_W'(gain_q) + RND_PAN;
  assign mul_r = MUL_W'(cos_r) * MUL_W'(gain_q) + RND_PAN;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_gain  <= '0;
      right_gain <= '0;
    end else if (commit) begin
      left_gain  <= mul_l[15 +: PAN_W];
      right_gain <= mul_r[15 +: PAN_W];
    end
  end

endmodule

>>> rtl/sopm_scale.sv
// ----------------------------------------------------------------------------
// sopm_scale
// Output scaling: accumulator times 1/sqrt(n), rounded, times the smoothed
// gain, rounded and saturated. Two multiply stages.
// ----------------------------------------------------------------------------
module sopm_scale (
  input  logic                                 clk,
  input  sopm_pkg::scale_ctl_t                 ctl,
  input  logic signed [sopm_pkg::ACC_W-1:0]    acc_left,
  input  logic signed [sopm_pkg::ACC_W-1:0]    acc_right,
  input  logic [sopm_pkg::NORM_W-1:0]          norm,
  input  logic [sopm_pkg::GAIN_W-1:0]          smoothed_gain,
  output logic signed [sopm_pkg::SAMPLE_W-1:0] left_y,
  output logic signed [sopm_pkg::SAMPLE_W-1:0] right_y
);
  import sopm_pkg::*;

  localparam int P_W = ACC_W + NORM_W + 1;
  localparam int T_W = ACC_W + 2;
  localparam int Q_W = T_W + GAIN_W + 1;
  localparam logic signed [P_W-1:0] RND_T = P_W'(1) << 14;
  localparam logic signed [Q_W-1:0] RND_Y = Q_W'(1) << 23;
  localparam logic signed [Q_W-1:0] Y_MAX = (Q_W'(1) << (SAMPLE_BITS - 1)) - Q_W'(1);
  localparam logic signed [Q_W-1:0] Y_MIN = -Y_MAX - Q_W'(1);

  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [Q_W-1:0] q
  );
    logic signed [Q_W-1:0] y;
    y = (q + RND_Y) >>> 24;
    if (y > Y_MAX) begin
      return SAMPLE_W'(Y_MAX);
    end
    if (y < Y_MIN) begin
      return SAMPLE_W'(Y_MIN);
    end
    return SAMPLE_W'(y);
  endfunction

  logic signed [P_W-1:0] p_l;
  logic signed [P_W-1:0] p_r;
  logic signed [P_W-1:0] ps_l;
  logic signed [P_W-1:0] ps_r;
  logic signed [T_W-1:0] t_l;
  logic signed [T_W-1:0] t_r;
  logic signed [Q_W-1:0] q_l;
  logic signed [Q_W-1:0] q_r;
  logic signed [NORM_W:0] norm_s;
  logic signed [GAIN_W:0] gain_s;

  assign norm_s = {1'b0, norm};
  assign gain_s = {1'b0, smoothed_gain};

  always_ff @(posedge clk) begin
    if (ctl.mul_norm) begin
      p_l <= acc_left * norm_s;
      p_r <= acc_right * norm_s;
    end
  end

  assign ps_l = p_l + RND_T;
  assign ps_r = p_r + RND_T;
  assign t_l  = T_W'(ps_l >>> 15);
  assign t_r  = T_W'(ps_r >>> 15);

  always_ff @(posedge clk) begin
    if (ctl.mul_gain) begin
      q_l <= t_l * gain_s;
      q_r <= t_r * gain_s;
    end
  end

  assign left_y  = round_sat(q_l);
  assign right_y = round_sat(q_r);

endmodule

>>> rtl/stereo_pan_object_mixer_top.sv
// ----------------------------------------------------------------------------
// stereo_pan_object_mixer_top
// Mixes panned mono objects into a stereo frame store and reads out scaled,
// saturated frames.
// ----------------------------------------------------------------------------
// Throughput: one item at a time. Header commits the pan gains; begin block and
//   sample multiply, then add or write back; read frame waits while the result register is full.
// Read frame: the result passes the frame store read, norm multiply, gain
//   multiply and result register, and is held until taken.
// Reset: synchronous; afterwards the frame store is zeroed one entry a cycle,
//   all FRAME_DEPTH entries, with in_ready low; configuration writes still apply.
module stereo_pan_object_mixer_top #(
  parameter int FRAME_DEPTH = 256,
  parameter int MAX_OBJECTS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              opcode,
  input  logic [sopm_pkg::FRAME_W-1:0]            frame_index,
  input  logic signed [sopm_pkg::SAMPLE_W-1:0]    sample_value,
  input  logic signed [sopm_pkg::AZ_W-1:0]        azimuth,
  input  logic [sopm_pkg::GAIN_W-1:0]             object_gain,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [sopm_pkg::SAMPLE_W-1:0]    left_out,
  output logic signed [sopm_pkg::SAMPLE_W-1:0]    right_out,
  output logic [sopm_pkg::FRAME_W-1:0]            frame_out,
  input  logic                                    cfg_we,
  input  logic [sopm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sopm_pkg::CFG_W-1:0]              cfg_data
);
  import sopm_pkg::*;

  localparam int SLOT_W = $clog2(FRAME_DEPTH);
  localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBJECTS);
  localparam int SM_W = 32;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SMOOTH1 = 4'd1;
  localparam logic [3:0] S_SMOOTH2 = 4'd2;
  localparam logic [3:0] S_PAN     = 4'd3;
  localparam logic [3:0] S_SAMP1   = 4'd4;
  localparam logic [3:0] S_SAMP2   = 4'd5;
  localparam logic [3:0] S_RD1     = 4'd6;
  localparam logic [3:0] S_RD2     = 4'd7;
  localparam logic [3:0] S_RD3     = 4'd8;

  localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] ACC_MIN = {2'b11, {(ACC_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
    if (s > ACC_MAX) begin
      return ACC_W'(ACC_MAX);
    end
    if (s < ACC_MIN) begin
      return ACC_W'(ACC_MIN);
    end
    return ACC_W'(s);
  endfunction

  // frame index to slot, and 1/sqrt(n) in Q1.15
  logic [SLOT_W-1:0] slot_lut [FRAME_RANGE];
  logic [NORM_W-1:0] norm_lut [MAX_OBJECTS+1];

  for (genvar g = 0; g < FRAME_RANGE; g++) begin : g_slot
    localparam int SLOT_V = g % FRAME_DEPTH;
    assign slot_lut[g] = SLOT_W'(SLOT_V);
  end

  for (genvar g = 0; g <= MAX_OBJECTS; g++) begin : g_norm
    localparam logic [32:0] QUOT = 33'h1_0000_0000 / ((g <= 1) ? 1 : g);
    localparam logic [16:0] ROOT = isqrt33(QUOT);
    localparam logic [NORM_W-1:0] NORM_V =
      (g <= 1) ? 16'd32768 : NORM_W'((ROOT + 17'd1) >> 1);
    assign norm_lut[g] = NORM_V;
  end

  logic [3:0]               state;
  logic [3:0]               state_next;
  logic                     accept;
  logic                     clearing;
  logic                     mixer_enabled;
  logic [GAIN_W-1:0]        output_gain_target;
  logic [GAIN_W-1:0]        smoothed_gain;
  logic                     smooth_loaded;
  logic [CNT_W-1:0]         active_count;
  logic [SM_W-1:0]          smooth_prod;
  logic [SM_W-1:0]          smooth_sum;
  logic [SLOT_W-1:0]        slot_q;
  logic [FRAME_W-1:0]       frame_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [PAN_W-1:0]         left_gain;
  logic [PAN_W-1:0]         right_gain;
  logic signed [PROD_W-1:0] prod_l;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W:0]    sum_l;
  logic signed [ACC_W:0]    sum_r;
  logic signed [ACC_W-1:0]  rd_left;
  logic signed [ACC_W-1:0]  rd_right;
  logic                     wr_en;
  logic signed [ACC_W-1:0]  wr_left;
  logic signed [ACC_W-1:0]  wr_right;
  scale_ctl_t               scale_ctl;
  logic signed [SAMPLE_W-1:0] left_y;
  logic signed [SAMPLE_W-1:0] right_y;
  logic                     out_load;

  assign in_ready = (state == S_IDLE) && !clearing;
  assign accept   = in_valid && in_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mixer_enabled      <= 1'b0;
      output_gain_target <= TARGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIXER_ENABLED: mixer_enabled      <= cfg_data[0];
        REG_GAIN_TARGET:   output_gain_target <= cfg_data[GAIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_BEGIN:  state_next = S_SMOOTH1;
            OP_HEADER: state_next = S_PAN;
            OP_SAMPLE: state_next = S_SAMP1;
            OP_READ:   state_next = S_RD1;
          endcase
        end
      end
      S_SMOOTH1: state_next = S_SMOOTH2;
      S_SMOOTH2: state_next = S_IDLE;
      S_PAN:     state_next = S_IDLE;
      S_SAMP1:   state_next = S_SAMP2;
      S_SAMP2:   state_next = S_IDLE;
      S_RD1:     state_next = S_RD2;
      S_RD2:     state_next = S_RD3;
      S_RD3: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_q   <= slot_lut[frame_index];
      frame_q  <= frame_index;
      sample_q <= sample_value;
    end
  end

  // object count and output gain smoothing
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
    end else if (accept && opcode == OP_BEGIN) begin
      active_count <= '0;
    end else if (accept && opcode == OP_HEADER && object_gain >= GAIN_THRESHOLD &&
                 active_count < CNT_MAX) begin
      active_count <= active_count + 1'b1;
    end
  end

  assign smooth_sum = smooth_prod + SM_W'(ALPHA_REM_Q15) * SM_W'(smoothed_gain)
                      + SM_W'(16384);

  always_ff @(posedge clk) begin
    if (state == S_SMOOTH1) begin
      smooth_prod <= SM_W'(ALPHA_Q15) * SM_W'(output_gain_target);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_gain <= '0;
      smooth_loaded <= 1'b0;
    end else if (state == S_SMOOTH2) begin
      smooth_loaded <= 1'b1;
      smoothed_gain <= smooth_loaded ? smooth_sum[15 +: GAIN_W] : output_gain_target;
    end
  end

  sopm_pan u_pan (
    .clk         (clk),
    .rst         (rst),
    .load        (accept && opcode == OP_HEADER),
    .commit      (state == S_PAN),
    .azimuth     (azimuth),
    .object_gain (object_gain),
    .left_gain   (left_gain),
    .right_gain  (right_gain)
  );

  // sample accumulation
  always_ff @(posedge clk) begin
    if (state == S_SAMP1) begin
      prod_l <= sample_q * $signed({1'b0, left_gain});
      prod_r <= sample_q * $signed({1'b0, right_gain});
    end
  end

  assign sum_l = {rd_left[ACC_W-1], rd_left}
               + {{(ACC_W+1-PROD_W){prod_l[PROD_W-1]}}, prod_l};
  assign sum_r = {rd_right[ACC_W-1], rd_right}
               + {{(ACC_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    wr_en    = (state == S_SAMP2) || (state == S_RD1);
    wr_left  = (state == S_SAMP2) ? sat_acc(sum_l) : '0;
    wr_right = (state == S_SAMP2) ? sat_acc(sum_r) : '0;
  end

  sopm_frame_store #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (slot_lut[frame_index]),
    .wr_en    (wr_en),
    .wr_addr  (slot_q),
    .wr_left  (wr_left),
    .wr_right (wr_right),
    .rd_left  (rd_left),
    .rd_right (rd_right),
    .clearing (clearing)
  );

  assign scale_ctl.mul_norm = (state == S_RD1);
  assign scale_ctl.mul_gain = (state == S_RD2);

  sopm_scale u_scale (
    .clk           (clk),
    .ctl           (scale_ctl),
    .acc_left      (rd_left),
    .acc_right     (rd_right),
    .norm          (norm_lut[active_count]),
    .smoothed_gain (smoothed_gain),
    .left_y        (left_y),
    .right_y       (right_y)
  );

  // result register
  assign out_load = (state == S_RD3) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out  <= mixer_enabled ? left_y : '0;
      right_out <= mixer_enabled ? right_y : '0;
      frame_out <= frame_q;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    active_count <= CNT_MAX)
    else $error("active count above limit");

  a_loaded_sticky: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(smooth_loaded)) |-> smooth_loaded)
    else $error("smooth_loaded dropped");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted item not processed");

  a_result_frame: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && frame_out == $past(frame_q))
    else $error("result not presented with its frame");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !clearing)
    else $error("frame store write during clearing");

endmodule
